/* rtl/ibwt_pkg.sv */
package ibwt_pkg;

    localparam int BLOCK_LENGTH = 4096;
    localparam int ADDR_W       = $clog2(BLOCK_LENGTH);
    localparam int LEN_W        = ADDR_W + 1;
    localparam int SYMBOLS      = 256;
    localparam int SYM_W        = 8;
    localparam int SCAN_W       = SYM_W + 1;
    localparam int PIDX_W       = 17;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EMIT = 1'b1;

endpackage

/* rtl/inverse_bwt_block_decoder_core.sv */
// Load beat: accept, then memory write and histogram update in S_LOAD before the next accept.
// Sealing load: plus a prefix scan over the 256-entry histogram, then
// successor fill (one byte per cycle through the RMW pipe); a negative primary index seals in copy mode without either.
// Emit beat: result registered after accept; copy mode reads the byte store, decoding reads the successor store
// and then the byte store; loading the output register (held while the result stalls) frees the input side.
// Reset: control cleared at once; histogram flagged invalid by 256 valid bits, stores not cleared.
module inverse_bwt_block_decoder_core
    import ibwt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic                     action,
    input  logic [SYM_W-1:0]         data_byte,
    input  logic                     last_byte,
    input  logic signed [PIDX_W-1:0] primary_index,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [SYM_W-1:0]         out_byte,
    output logic                     last_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_PREFIX,
        S_FILL,
        S_EM_SUCC,
        S_EM_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    emitted_reg, emitted_next;
    logic [ADDR_W-1:0]   cursor_reg, cursor_next;
    logic                copy_reg, copy_next;
    logic                sealed_reg, sealed_next;
    logic [SYMBOLS-1:0]  hv_reg, hv_next;
    logic [SYM_W-1:0]    data_reg, data_next;
    logic                last_reg, last_next;
    logic [PIDX_W-1:0]   pidx_reg, pidx_next;
    logic [SCAN_W-1:0]   p_cnt_reg, p_cnt_next;
    logic [LEN_W-1:0]    sum_reg, sum_next;
    logic [LEN_W-1:0]    f_rd_reg, f_rd_next;
    logic                s1_v_reg, s1_v_next;
    logic [ADDR_W-1:0]   s1_i_reg, s1_i_next;
    logic                s2_v_reg, s2_v_next;
    logic [ADDR_W-1:0]   s2_i_reg, s2_i_next;
    logic [SYM_W-1:0]    s2_b_reg, s2_b_next;
    logic                wr_v_reg, wr_v_next;
    logic [SYM_W-1:0]    wr_b_reg, wr_b_next;
    logic [LEN_W-1:0]    wr_val_reg, wr_val_next;
    logic                out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]    out_byte_reg, out_byte_next;
    logic                last_out_reg, last_out_next;

    logic [SYM_W-1:0]    byte_mem [BLOCK_LENGTH];
    logic                byte_we, byte_re;
    logic [ADDR_W-1:0]   byte_waddr, byte_raddr;
    logic [SYM_W-1:0]    byte_wdata, byte_rdata_reg;

    logic [LEN_W-1:0]    hist_mem [SYMBOLS];
    logic                hist_we, hist_re;
    logic [SYM_W-1:0]    hist_waddr, hist_raddr;
    logic [LEN_W-1:0]    hist_wdata, hist_rdata_reg;

    logic [ADDR_W-1:0]   succ_mem [BLOCK_LENGTH];
    logic                succ_we, succ_re;
    logic [ADDR_W-1:0]   succ_waddr, succ_raddr, succ_wdata, succ_rdata_reg;

    logic                item_accept;
    logic                store_full;
    logic [LEN_W-1:0]    len_after;
    logic [PIDX_W-1:0]   pidx_pos, len_wide;
    logic [SYM_W-1:0]    p_idx;
    logic [LEN_W-1:0]    fill_start;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_out     = last_out_reg;

    assign store_full = (len_reg >= LEN_W'(BLOCK_LENGTH));
    assign len_after  = store_full ? len_reg : LEN_W'(len_reg + 1'b1);
    assign pidx_pos   = {1'b0, pidx_reg[PIDX_W-2:0]};
    assign len_wide   = PIDX_W'(len_after);
    assign p_idx      = SYM_W'(p_cnt_reg[SYM_W-1:0] - 1'b1);
    assign fill_start = (wr_v_reg && (wr_b_reg == s2_b_reg)) ? wr_val_reg : hist_rdata_reg;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        emitted_next   = emitted_reg;
        cursor_next    = cursor_reg;
        copy_next      = copy_reg;
        sealed_next    = sealed_reg;
        hv_next        = hv_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        pidx_next      = pidx_reg;
        p_cnt_next     = p_cnt_reg;
        sum_next       = sum_reg;
        f_rd_next      = f_rd_reg;
        s1_v_next      = 1'b0;
        s1_i_next      = s1_i_reg;
        s2_v_next      = 1'b0;
        s2_i_next      = s2_i_reg;
        s2_b_next      = s2_b_reg;
        wr_v_next      = 1'b0;
        wr_b_next      = wr_b_reg;
        wr_val_next    = wr_val_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_byte_next  = out_byte_reg;
        last_out_next  = last_out_reg;

        byte_we    = 1'b0;
        byte_waddr = len_reg[ADDR_W-1:0];
        byte_wdata = data_reg;
        byte_re    = 1'b0;
        byte_raddr = emitted_reg[ADDR_W-1:0];
        hist_we    = 1'b0;
        hist_waddr = data_reg;
        hist_wdata = LEN_W'(1);
        hist_re    = 1'b0;
        hist_raddr = data_byte;
        succ_we    = 1'b0;
        succ_waddr = fill_start[ADDR_W-1:0];
        succ_wdata = s2_i_reg;
        succ_re    = 1'b0;
        succ_raddr = cursor_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_accept && (action == ACT_LOAD))
                begin
                    if (sealed_reg)
                    begin
                        hv_next      = '0;
                        len_next     = '0;
                        emitted_next = '0;
                        cursor_next  = '0;
                        copy_next    = 1'b0;
                        sealed_next  = 1'b0;
                    end
                    hist_re    = 1'b1;
                    hist_raddr = data_byte;
                    data_next  = data_byte;
                    last_next  = last_byte;
                    pidx_next  = primary_index;
                    state_next = S_LOAD;
                end
                else if (item_accept && sealed_reg && (emitted_reg < len_reg))
                begin
                    if (copy_reg)
                    begin
                        byte_re    = 1'b1;
                        byte_raddr = emitted_reg[ADDR_W-1:0];
                        state_next = S_EM_OUT;
                    end
                    else
                    begin
                        succ_re    = 1'b1;
                        succ_raddr = cursor_reg;
                        state_next = S_EM_SUCC;
                    end
                end
            end
            S_LOAD:
            begin
                if (!store_full)
                begin
                    byte_we          = 1'b1;
                    byte_waddr       = len_reg[ADDR_W-1:0];
                    hist_we          = 1'b1;
                    hist_waddr       = data_reg;
                    hist_wdata       = LEN_W'((hv_reg[data_reg] ? hist_rdata_reg : '0) + 1'b1);
                    hv_next[data_reg] = 1'b1;
                    len_next         = len_after;
                end
                state_next = S_IDLE;
                if (last_reg)
                begin
                    emitted_next = '0;
                    cursor_next  = '0;
                    if (pidx_reg[PIDX_W-1])
                    begin
                        copy_next   = 1'b1;
                        sealed_next = 1'b1;
                    end
                    else
                    begin
                        copy_next = 1'b0;
                        if (pidx_pos >= len_wide)
                            cursor_next = ADDR_W'(len_after - 1'b1);
                        else
                            cursor_next = pidx_pos[ADDR_W-1:0];
                        p_cnt_next = '0;
                        sum_next   = '0;
                        state_next = S_PREFIX;
                    end
                end
            end
            S_PREFIX:
            begin
                if (!p_cnt_reg[SCAN_W-1])
                begin
                    hist_re    = 1'b1;
                    hist_raddr = p_cnt_reg[SYM_W-1:0];
                end
                if (p_cnt_reg != '0)
                begin
                    hist_we        = 1'b1;
                    hist_waddr     = p_idx;
                    hist_wdata     = sum_reg;
                    sum_next       = LEN_W'(sum_reg + (hv_reg[p_idx] ? hist_rdata_reg : '0));
                    hv_next[p_idx] = 1'b1;
                end
                p_cnt_next = SCAN_W'(p_cnt_reg + 1'b1);
                if (p_cnt_reg[SCAN_W-1])
                begin
                    f_rd_next  = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (f_rd_reg < len_reg)
                begin
                    byte_re    = 1'b1;
                    byte_raddr = f_rd_reg[ADDR_W-1:0];
                    s1_v_next  = 1'b1;
                    s1_i_next  = f_rd_reg[ADDR_W-1:0];
                    f_rd_next  = LEN_W'(f_rd_reg + 1'b1);
                end
                if (s1_v_reg)
                begin
                    hist_re    = 1'b1;
                    hist_raddr = byte_rdata_reg;
                    s2_v_next  = 1'b1;
                    s2_i_next  = s1_i_reg;
                    s2_b_next  = byte_rdata_reg;
                end
                if (s2_v_reg)
                begin
                    succ_we     = 1'b1;
                    succ_waddr  = fill_start[ADDR_W-1:0];
                    succ_wdata  = s2_i_reg;
                    hist_we     = 1'b1;
                    hist_waddr  = s2_b_reg;
                    hist_wdata  = LEN_W'(fill_start + 1'b1);
                    wr_v_next   = 1'b1;
                    wr_b_next   = s2_b_reg;
                    wr_val_next = LEN_W'(fill_start + 1'b1);
                end
                if ((f_rd_reg >= len_reg) && !s1_v_reg && !s2_v_reg)
                begin
                    sealed_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_EM_SUCC:
            begin
                cursor_next = succ_rdata_reg;
                byte_re     = 1'b1;
                byte_raddr  = succ_rdata_reg;
                state_next  = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = byte_rdata_reg;
                    last_out_next  = (LEN_W'(emitted_reg + 1'b1) == len_reg);
                    emitted_next   = LEN_W'(emitted_reg + 1'b1);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            emitted_reg   <= '0;
            cursor_reg    <= '0;
            copy_reg      <= 1'b0;
            sealed_reg    <= 1'b0;
            hv_reg        <= '0;
            data_reg      <= '0;
            last_reg      <= 1'b0;
            pidx_reg      <= '0;
            p_cnt_reg     <= '0;
            sum_reg       <= '0;
            f_rd_reg      <= '0;
            s1_v_reg      <= 1'b0;
            s1_i_reg      <= '0;
            s2_v_reg      <= 1'b0;
            s2_i_reg      <= '0;
            s2_b_reg      <= '0;
            wr_v_reg      <= 1'b0;
            wr_b_reg      <= '0;
            wr_val_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            last_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            emitted_reg   <= emitted_next;
            cursor_reg    <= cursor_next;
            copy_reg      <= copy_next;
            sealed_reg    <= sealed_next;
            hv_reg        <= hv_next;
            data_reg      <= data_next;
            last_reg      <= last_next;
            pidx_reg      <= pidx_next;
            p_cnt_reg     <= p_cnt_next;
            sum_reg       <= sum_next;
            f_rd_reg      <= f_rd_next;
            s1_v_reg      <= s1_v_next;
            s1_i_reg      <= s1_i_next;
            s2_v_reg      <= s2_v_next;
            s2_i_reg      <= s2_i_next;
            s2_b_reg      <= s2_b_next;
            wr_v_reg      <= wr_v_next;
            wr_b_reg      <= wr_b_next;
            wr_val_reg    <= wr_val_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            last_out_reg  <= last_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
            byte_mem[byte_waddr] <= byte_wdata;
        if (byte_re)
            byte_rdata_reg <= byte_mem[byte_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        if (hist_re)
            hist_rdata_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (succ_we)
            succ_mem[succ_waddr] <= succ_wdata;
        if (succ_re)
            succ_rdata_reg <= succ_mem[succ_raddr];
    end

endmodule
